FILE: src/grid_shortest_path_search_unit_defines.svh
// assertion macros shared by the grid shortest path search unit
`ifndef GRID_SHORTEST_PATH_SEARCH_UNIT_DEFINES_SVH
`define GRID_SHORTEST_PATH_SEARCH_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define GSP_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("grid search assertion failed");

// next-cycle implication, disabled during reset
`define GSP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("grid search assertion failed");

`endif

FILE: src/gsp_pkg.sv
// types and constants of the grid shortest path search unit
package gsp_pkg;

   localparam int FIELD_W  = 6;
   localparam int COST_W   = 12;
   localparam int NUM_DIRS = 8;

   localparam logic [COST_W-1:0] COST_MAX = 12'hFFF;

   // neighbor offsets in ascending (row, col) order of the neighbor
   localparam int CHAIN_ROW_STEP [NUM_DIRS] = '{-1, -1, -1, 0, 0, 1, 1, 1};
   localparam int CHAIN_COL_STEP [NUM_DIRS] = '{-1, 0, 1, -1, 1, -1, 0, 1};

   typedef enum logic [1:0] {
      ACT_WRITE  = 2'd0,
      ACT_SEARCH = 2'd1,
      ACT_READ   = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      CSR_START_ROW = 2'd0,
      CSR_START_COL = 2'd1,
      CSR_END_ROW   = 2'd2,
      CSR_END_COL   = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SEED,
      ST_POP,
      ST_POPWAIT,
      ST_PROBE,
      ST_ENDRD,
      ST_ENDCHK,
      ST_PARAPPLY,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [1:0]         action;
      logic [FIELD_W-1:0] cell_row;
      logic [FIELD_W-1:0] cell_col;
      logic               cell_open;
   } req_type;

   typedef struct packed {
      logic [COST_W-1:0]  path_cost;
      logic               reachable;
      logic [FIELD_W-1:0] path_row;
      logic [FIELD_W-1:0] path_col;
      logic               path_valid;
      logic               path_last;
   } rsp_type;

   // status of the neighbor probe presented by the cell chain
   typedef struct packed {
      logic in_grid;
      logic last;
   } probe_stat_type;

endpackage

FILE: src/gsp_probe_cell.sv
// one neighbor probe cell: holds the current cell token for one direction
module gsp_probe_cell
   import gsp_pkg::*;
#(
   parameter int GRID_SIZE = 64,
   parameter int ROW_STEP  = 0,
   parameter int COL_STEP  = 0
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 tok_valid_i,
   input  logic [$clog2(GRID_SIZE):0]           tok_row_i,
   input  logic [$clog2(GRID_SIZE):0]           tok_col_i,
   input  logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0] tok_dist_i,
   output logic                                 tok_valid_o,
   output logic [$clog2(GRID_SIZE):0]           tok_row_o,
   output logic [$clog2(GRID_SIZE):0]           tok_col_o,
   output logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0] tok_dist_o,
   output logic [$clog2(GRID_SIZE):0]           nb_row,
   output logic [$clog2(GRID_SIZE):0]           nb_col,
   output logic                                 nb_in_grid
);

   localparam int CW = $clog2(GRID_SIZE) + 1;
   localparam int DW = $clog2(GRID_SIZE * GRID_SIZE);

   logic          valid_ff;
   logic [CW-1:0] row_ff;
   logic [CW-1:0] col_ff;
   logic [DW-1:0] dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= tok_valid_i;
      end
      row_ff  <= tok_row_i;
      col_ff  <= tok_col_i;
      dist_ff <= tok_dist_i;
   end

   // a step below zero wraps to a large value and falls outside the grid
   assign nb_row     = row_ff + CW'(ROW_STEP);
   assign nb_col     = col_ff + CW'(COL_STEP);
   assign nb_in_grid = valid_ff && (32'(nb_row) < GRID_SIZE) && (32'(nb_col) < GRID_SIZE);

   assign tok_valid_o = valid_ff;
   assign tok_row_o   = row_ff;
   assign tok_col_o   = col_ff;
   assign tok_dist_o  = dist_ff;

endmodule

FILE: src/gsp_probe_chain.sv
// chain of eight probe cells, one per neighbor direction
module gsp_probe_chain
   import gsp_pkg::*;
#(
   parameter int GRID_SIZE = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 inj_valid,
   input  logic [$clog2(GRID_SIZE):0]           inj_row,
   input  logic [$clog2(GRID_SIZE):0]           inj_col,
   input  logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0] inj_dist,
   output logic [$clog2(GRID_SIZE):0]           probe_row,
   output logic [$clog2(GRID_SIZE):0]           probe_col,
   output logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0] probe_dist,
   output probe_stat_type                       probe_stat
);

`include "grid_shortest_path_search_unit_defines.svh"

   localparam int CW = $clog2(GRID_SIZE) + 1;
   localparam int DW = $clog2(GRID_SIZE * GRID_SIZE);

   logic          tok_vld  [NUM_DIRS+1];
   logic [CW-1:0] tok_row  [NUM_DIRS+1];
   logic [CW-1:0] tok_col  [NUM_DIRS+1];
   logic [DW-1:0] tok_dist [NUM_DIRS+1];
   logic [CW-1:0] nb_row   [NUM_DIRS];
   logic [CW-1:0] nb_col   [NUM_DIRS];
   logic [NUM_DIRS-1:0] nb_in_grid;
   logic [NUM_DIRS-1:0] cell_vld;

   assign tok_vld[0]  = inj_valid;
   assign tok_row[0]  = inj_row;
   assign tok_col[0]  = inj_col;
   assign tok_dist[0] = inj_dist;

   for (genvar k = 0; k < NUM_DIRS; k++) begin : g_cell
      gsp_probe_cell #(
         .GRID_SIZE (GRID_SIZE),
         .ROW_STEP  (CHAIN_ROW_STEP[k]),
         .COL_STEP  (CHAIN_COL_STEP[k])
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .tok_valid_i (tok_vld[k]),
         .tok_row_i   (tok_row[k]),
         .tok_col_i   (tok_col[k]),
         .tok_dist_i  (tok_dist[k]),
         .tok_valid_o (tok_vld[k+1]),
         .tok_row_o   (tok_row[k+1]),
         .tok_col_o   (tok_col[k+1]),
         .tok_dist_o  (tok_dist[k+1]),
         .nb_row      (nb_row[k]),
         .nb_col      (nb_col[k]),
         .nb_in_grid  (nb_in_grid[k])
      );
      assign cell_vld[k] = tok_vld[k+1];
   end

   // one token in flight, so at most one cell drives the memory address
   always_comb begin
      probe_row  = '0;
      probe_col  = '0;
      probe_dist = '0;
      for (int k = 0; k < NUM_DIRS; k++) begin
         probe_row  = probe_row  | (cell_vld[k] ? nb_row[k]      : '0);
         probe_col  = probe_col  | (cell_vld[k] ? nb_col[k]      : '0);
         probe_dist = probe_dist | (cell_vld[k] ? tok_dist[k+1]  : '0);
      end
      probe_stat.in_grid = |nb_in_grid;
      probe_stat.last    = cell_vld[NUM_DIRS-1];
   end

   `GSP_ASSERT_IMPLY(a_one_token, clock, reset, 1'b1, $onehot0(cell_vld))

endmodule

FILE: src/grid_shortest_path_search_unit.sv
// grid shortest path search unit: top level with map, distance and queue memories
// map writes, idle actions and reads with no walk pending go straight to emit; a walk read first runs a probe pass
// search: a clearing pass over all GRID_SIZE*GRID_SIZE cells, then for each reached cell a queue pop
//    plus the 8-cell probe chain and its check stage, then a read and check of the end cell,
//    and a parent lookup through the chain when the end cell is reached
// one request at a time; a request is taken while the previous result still waits
// reset: synchronous, cost 4095, not reachable, no walk pending, registers zero
module grid_shortest_path_search_unit
   import gsp_pkg::*;
#(
   parameter int GRID_SIZE = 64
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_data,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data,
   // register write port
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [FIELD_W-1:0] csr_wdata
);

`include "grid_shortest_path_search_unit_defines.svh"

   localparam int CELLS = GRID_SIZE * GRID_SIZE;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(GRID_SIZE) + 1;
   localparam int DW    = $clog2(CELLS);
   localparam int QW    = 2 * CW + DW;

   // control state
   state_type state_ff, state_in;

   // configuration registers
   logic [FIELD_W-1:0] start_row_ff, start_col_ff, end_row_ff, end_col_ff;

   // search source, latched when a search starts so later writes leave the walk alone
   logic [CW-1:0] src_r_ff, src_c_ff;
   logic          src_ok_ff;

   // walk cursor and its distance from the source
   logic [CW-1:0] cur_r_ff, cur_c_ff;
   logic [DW-1:0] cur_d_ff;

   // reported status
   logic [COST_W-1:0] cost_ff;
   logic              found_ff;
   logic              walk_act_ff;

   // frontier queue pointers and clearing sweep
   logic [AW:0]   head_ff, tail_ff;
   logic [AW-1:0] clr_ff;

   // per request path fields
   logic [FIELD_W-1:0] res_r_ff, res_c_ff;
   logic               res_v_ff;

   // parent search capture
   logic          par_mode_ff, par_hit_ff;
   logic [CW-1:0] par_r_ff, par_c_ff;

   // check stage behind the probe chain
   probe_stat_type chk_stat_ff;
   logic [CW-1:0]  chk_r_ff, chk_c_ff;
   logic [DW-1:0]  chk_d_ff;

   // memories and their registered read data
   logic          open_mem [CELLS];
   logic [DW:0]   vd_mem   [CELLS];
   logic [QW-1:0] q_mem    [CELLS];
   logic          open_rd_ff;
   logic          vis_rd_ff;
   logic [DW-1:0] dist_rd_ff;
   logic [QW-1:0] q_rd_ff;

   // result register
   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   // chain connections
   logic           inj_valid, inj_par;
   logic [CW-1:0]  inj_row, inj_col;
   logic [DW-1:0]  inj_dist;
   logic [CW-1:0]  probe_row, probe_col;
   logic [DW-1:0]  probe_dist;
   probe_stat_type probe_stat;

   // control strobes
   logic          req_accept, rsp_free;
   logic          is_read_walk;
   logic          map_ok, end_ok, end_hit, end_is_src;
   logic          bfs_hit, par_match;
   logic          open_we;
   logic [AW-1:0] open_waddr;
   logic          vd_we, q_we;
   logic [AW-1:0] vd_waddr, rd_addr;
   logic [DW:0]   vd_wdata;
   logic [QW-1:0] q_wdata;
   logic [CW-1:0] end_r_cw, end_c_cw;

   function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
      cell_addr = AW'(AW'(r) * AW'(GRID_SIZE) + AW'(c));
   endfunction

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   assign map_ok   = (32'(req_data.cell_row) < GRID_SIZE) && (32'(req_data.cell_col) < GRID_SIZE);
   assign end_ok   = (32'(end_row_ff) < GRID_SIZE) && (32'(end_col_ff) < GRID_SIZE);
   assign end_r_cw = CW'(end_row_ff);
   assign end_c_cw = CW'(end_col_ff);
   // end cell reached only if the source was inside the grid
   assign end_hit    = end_ok && vis_rd_ff;
   assign end_is_src = (end_r_cw == src_r_ff) && (end_c_cw == src_c_ff);
   assign is_read_walk = (req_data.action == ACT_READ) && walk_act_ff;

   // newly discovered neighbor during the breadth-first pass
   assign bfs_hit = (state_ff == ST_PROBE) && !par_mode_ff && chk_stat_ff.in_grid
                    && open_rd_ff && !vis_rd_ff;
   // neighbor one step nearer the source during the walk back
   assign par_match = (state_ff == ST_PROBE) && par_mode_ff && chk_stat_ff.in_grid
                      && vis_rd_ff && (dist_rd_ff == chk_d_ff - DW'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_data.action == ACT_SEARCH) begin
                  state_in = ST_CLEAR;
               end else if (is_read_walk) begin
                  state_in = ST_PROBE;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_CLEAR: begin
            if (clr_ff == AW'(CELLS - 1)) begin
               state_in = src_ok_ff ? ST_SEED : ST_EMIT;
            end
         end
         ST_SEED:    state_in = ST_POP;
         ST_POP:     state_in = (head_ff == tail_ff) ? ST_ENDRD : ST_POPWAIT;
         ST_POPWAIT: state_in = ST_PROBE;
         ST_PROBE: begin
            if (chk_stat_ff.last) begin
               state_in = par_mode_ff ? ST_PARAPPLY : ST_POP;
            end
         end
         ST_ENDRD:  state_in = ST_ENDCHK;
         ST_ENDCHK: state_in = (end_hit && !end_is_src) ? ST_PROBE : ST_EMIT;
         ST_PARAPPLY: state_in = ST_EMIT;
         ST_EMIT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // memory ports and chain injection
   always_comb begin
      open_we    = 1'b0;
      open_waddr = cell_addr(CW'(req_data.cell_row), CW'(req_data.cell_col));
      vd_we      = 1'b0;
      vd_waddr   = cell_addr(chk_r_ff, chk_c_ff);
      vd_wdata   = {1'b1, chk_d_ff + DW'(1)};
      q_we       = 1'b0;
      q_wdata    = {chk_r_ff, chk_c_ff, chk_d_ff + DW'(1)};
      rd_addr    = cell_addr(probe_row, probe_col);
      inj_valid  = 1'b0;
      inj_par    = 1'b0;
      inj_row    = cur_r_ff;
      inj_col    = cur_c_ff;
      inj_dist   = cur_d_ff;
      unique case (state_ff)
         ST_IDLE: begin
            open_we   = req_accept && (req_data.action == ACT_WRITE) && map_ok;
            inj_valid = req_accept && is_read_walk;
            inj_par   = 1'b1;
         end
         ST_CLEAR: begin
            vd_we    = 1'b1;
            vd_waddr = clr_ff;
            vd_wdata = '0;
         end
         ST_SEED: begin
            vd_we    = 1'b1;
            vd_waddr = cell_addr(src_r_ff, src_c_ff);
            vd_wdata = {1'b1, DW'(0)};
            q_we     = 1'b1;
            q_wdata  = {src_r_ff, src_c_ff, DW'(0)};
         end
         ST_POPWAIT: begin
            inj_valid = 1'b1;
            inj_row   = q_rd_ff[QW-1 -: CW];
            inj_col   = q_rd_ff[DW +: CW];
            inj_dist  = q_rd_ff[DW-1:0];
         end
         ST_PROBE: begin
            vd_we = bfs_hit;
            q_we  = bfs_hit;
         end
         ST_ENDRD: begin
            rd_addr = cell_addr(end_r_cw, end_c_cw);
         end
         ST_ENDCHK: begin
            inj_valid = end_hit && !end_is_src;
            inj_par   = 1'b1;
            inj_row   = end_r_cw;
            inj_col   = end_c_cw;
            inj_dist  = dist_rd_ff;
         end
         ST_POP, ST_PARAPPLY, ST_EMIT: begin
         end
         default: begin
         end
      endcase
   end

   // memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (open_we) begin
         open_mem[open_waddr] <= req_data.cell_open;
      end
      open_rd_ff <= open_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (vd_we) begin
         vd_mem[vd_waddr] <= vd_wdata;
      end
      {vis_rd_ff, dist_rd_ff} <= vd_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (q_we) begin
         q_mem[tail_ff[AW-1:0]] <= q_wdata;
      end
      q_rd_ff <= q_mem[head_ff[AW-1:0]];
   end

   gsp_probe_chain #(
      .GRID_SIZE (GRID_SIZE)
   ) u_chain (
      .clock      (clock),
      .reset      (reset),
      .inj_valid  (inj_valid),
      .inj_row    (inj_row),
      .inj_col    (inj_col),
      .inj_dist   (inj_dist),
      .probe_row  (probe_row),
      .probe_col  (probe_col),
      .probe_dist (probe_dist),
      .probe_stat (probe_stat)
   );

   // check stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         chk_stat_ff <= '0;
      end else begin
         chk_stat_ff <= probe_stat;
      end
      chk_r_ff <= probe_row;
      chk_c_ff <= probe_col;
      chk_d_ff <= probe_dist;
   end

   // control and status registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_row_ff <= '0;
         start_col_ff <= '0;
         end_row_ff   <= '0;
         end_col_ff   <= '0;
         cost_ff      <= COST_MAX;
         found_ff     <= 1'b0;
         walk_act_ff  <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         par_hit_ff   <= 1'b0;
         par_mode_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_START_ROW: start_row_ff <= csr_wdata;
               CSR_START_COL: start_col_ff <= csr_wdata;
               CSR_END_ROW:   end_row_ff   <= csr_wdata;
               CSR_END_COL:   end_col_ff   <= csr_wdata;
               default: begin
               end
            endcase
         end

         if (inj_valid) begin
            par_mode_ff <= inj_par;
            par_hit_ff  <= 1'b0;
         end

         if (state_ff == ST_IDLE && req_accept && req_data.action == ACT_SEARCH) begin
            found_ff    <= 1'b0;
            cost_ff     <= COST_MAX;
            walk_act_ff <= 1'b0;
            head_ff     <= '0;
            tail_ff     <= '0;
         end

         if (q_we) begin
            tail_ff <= tail_ff + (AW+1)'(1);
         end
         if (state_ff == ST_POP && head_ff != tail_ff) begin
            head_ff <= head_ff + (AW+1)'(1);
         end

         // lowest neighbor wins: keep the first match the chain produces
         if (par_match && !par_hit_ff) begin
            par_hit_ff <= 1'b1;
         end

         if (state_ff == ST_ENDCHK && end_hit) begin
            found_ff <= 1'b1;
            cost_ff  <= (32'(dist_rd_ff) > 32'(COST_MAX)) ? COST_MAX : COST_W'(dist_rd_ff);
         end

         if (state_ff == ST_PARAPPLY) begin
            walk_act_ff <= !((par_r_ff == src_r_ff) && (par_c_ff == src_c_ff));
         end

         if (state_ff == ST_EMIT && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_accept) begin
         res_v_ff <= is_read_walk;
         res_r_ff <= is_read_walk ? FIELD_W'(cur_r_ff) : '0;
         res_c_ff <= is_read_walk ? FIELD_W'(cur_c_ff) : '0;
         if (req_data.action == ACT_SEARCH) begin
            src_r_ff  <= CW'(start_row_ff);
            src_c_ff  <= CW'(start_col_ff);
            src_ok_ff <= (32'(start_row_ff) < GRID_SIZE) && (32'(start_col_ff) < GRID_SIZE);
            clr_ff    <= '0;
         end
      end
      if (state_ff == ST_CLEAR) begin
         clr_ff <= clr_ff + AW'(1);
      end
      if (par_match && !par_hit_ff) begin
         par_r_ff <= chk_r_ff;
         par_c_ff <= chk_c_ff;
      end
      if (state_ff == ST_ENDCHK && end_hit && !end_is_src) begin
         cur_r_ff <= end_r_cw;
         cur_c_ff <= end_c_cw;
         cur_d_ff <= dist_rd_ff;
      end
      if (state_ff == ST_PARAPPLY) begin
         cur_r_ff <= par_r_ff;
         cur_c_ff <= par_c_ff;
         cur_d_ff <= cur_d_ff - DW'(1);
      end
      if (state_ff == ST_EMIT && rsp_free) begin
         rsp_ff.path_cost  <= cost_ff;
         rsp_ff.reachable  <= found_ff;
         rsp_ff.path_row   <= res_r_ff;
         rsp_ff.path_col   <= res_c_ff;
         rsp_ff.path_valid <= res_v_ff;
         rsp_ff.path_last  <= !walk_act_ff;
      end
   end

   `GSP_ASSERT_IMPLY(a_walk_needs_found, clock, reset, walk_act_ff, found_ff)
   `GSP_ASSERT_IMPLY(a_queue_order, clock, reset, 1'b1, tail_ff >= head_ff)
   `GSP_ASSERT_IMPLY(a_check_in_probe, clock, reset, chk_stat_ff.last, state_ff == ST_PROBE)
   `GSP_ASSERT_NEXT(a_emit_loads, clock, reset, state_ff == ST_EMIT && rsp_free,
                    rsp_valid_ff && state_ff == ST_IDLE)

endmodule
